// ----- rtl/core/tbb_pkg.sv -----
// Shared constants, register codes and helper functions of the triple box blur.
package tbb_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_RADIUS    = 7;
	localparam int RING          = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W        = $clog2(RING);
	localparam int PIX_W         = 8;
	localparam int NCH           = 3;
	localparam int SUM_W         = $clog2(RING * 255 + 1);
	localparam int RECIP_W       = 15;
	localparam int RECIP_SHIFT   = 16;
	localparam int PROD_W        = SUM_W + RECIP_W;
	localparam int RAD_W         = 3;
	localparam int FW_W          = 11;
	localparam int FH_W          = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 12;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Reciprocal of the window size 2r+1, rounded up, scaled by 2^16.
	// Exact floor division for every sum a window can produce.
	function automatic logic [RECIP_W-1:0] recip_f(input logic [RAD_W-1:0] r);
		case (r)
			3'd2:    recip_f = 15'd13108;
			3'd3:    recip_f = 15'd9363;
			3'd4:    recip_f = 15'd7282;
			3'd5:    recip_f = 15'd5958;
			3'd6:    recip_f = 15'd5042;
			3'd7:    recip_f = 15'd4370;
			default: recip_f = 15'd21846;
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		slot_inc = (s == SLOT_W'(RING - 1)) ? '0 : s + 1'b1;
	endfunction

	// (s - d) modulo the ring size, for d below the ring size.
	function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
			input logic [SLOT_W-1:0] d);
		logic [SLOT_W:0] t;
		t = {1'b0, s} + (SLOT_W + 1)'(RING) - {1'b0, d};
		slot_sub = (s >= d) ? s - d : t[SLOT_W-1:0];
	endfunction

endpackage

// ----- rtl/core/triple_box_blur.sv -----
// Triple box blur: first pass per input pixel, then vertical and horizontal passes per output.
// A request leaves idle for the first pass columns it completes (one, or up to r+1 at the end
// of a row), each accumulated over its window, scaled and written, and then for the output check.
// When it emits a pixel, each of 2r+1 columns is summed vertically and scaled, the column results
// are summed and scaled; the emit waits while a previous pixel is not taken. Requests are taken
// only in idle. Reset (arst_n low) clears counters, sequencer and output valid.
module triple_box_blur
	import tbb_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      red_in,
	input  logic [PIX_W-1:0]      green_in,
	input  logic [PIX_W-1:0]      blue_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      red_out,
	output logic [PIX_W-1:0]      green_out,
	output logic [PIX_W-1:0]      blue_out,
	output logic                  frame_end,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int AW    = SLOT_W + CW;
	localparam int DEPTH = RING * (2 ** CW);
	localparam int PXW   = NCH * PIX_W;

	typedef enum logic [3:0] {
		IDLE, FP_ACC, FP_MUL, FP_WR, OUT_CHK,
		O_RD, O_LAST, O_MUL, O_ADD, O_FMUL, O_EMIT
	} state_t;

	state_t state_q;

	logic [RAD_W-1:0] rad_q;
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;

	logic [CW-1:0]     in_col_q, out_col_q;
	logic [FH_W-1:0]   in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_wslot_q, in_rslot_q, out_rslot_q;

	logic [PXW-1:0] win_q [RING];
	logic [PXW-1:0] mem [DEPTH];
	logic [PXW-1:0] mem_rd_q;

	// First pass sequencer.
	logic [CW-1:0]          fc_q, fe_q;
	logic signed [CW+1:0]   jv_q;
	logic [SLOT_W-1:0]      js_q, jst_q, fslot_q;
	logic [3:0]             k_q;
	logic [SUM_W-1:0]       sum_q [NCH];

	// Output sequencer.
	logic signed [CW+1:0]   cv_q;
	logic signed [FH_W+1:0] rv_q, rv0_q;
	logic [SLOT_W-1:0]      rs_q, rs0_q;
	logic [3:0]             kk_q, m_q;
	logic [SUM_W-1:0]       t_q [NCH];
	logic [SUM_W-1:0]       acc_q [NCH];
	logic                   rdv_s1;

	logic [PROD_W-1:0] prod_q [NCH];

	logic                 out_valid_q, frame_end_q;
	logic [PIX_W-1:0]     pix_q [NCH];

	logic [RAD_W-1:0]   r_eff;
	logic [3:0]         r2;
	logic [RECIP_W-1:0] recip;
	logic [CW-1:0]      wm1;
	logic [FH_W-1:0]    hm1;

	always_comb begin
		r_eff = (rad_q == '0) ? RAD_W'(1) : rad_q;
		if (int'(rad_q) > MAX_RADIUS) begin
			r_eff = RAD_W'(MAX_RADIUS);
		end
		if (fw_q == '0) begin
			wm1 = '0;
		end else if (int'(fw_q) > MAX_WIDTH) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(fw_q - 11'd1);
		end
	end

	assign r2    = {r_eff, 1'b0};
	assign recip = recip_f(r_eff);
	assign hm1   = (fh_q == '0) ? '0 : fh_q - 12'd1;

	// Input side decisions at acceptance.
	logic                 cx_ge_r, cx_ge_2r, cx_last, store;
	logic [CW-1:0]        c_start, c_end;
	logic signed [CW+1:0] jv0;
	logic [SLOT_W-1:0]    js0;

	assign cx_ge_r  = in_col_q >= CW'(r_eff);
	assign cx_ge_2r = in_col_q >= CW'(r2);
	assign cx_last  = in_col_q == wm1;
	assign store    = !opcode && (in_row_q <= hm1);
	assign c_start  = cx_ge_r ? in_col_q - CW'(r_eff) : '0;
	assign c_end    = cx_last ? wm1 : in_col_q - CW'(r_eff);
	assign jv0      = $signed({2'b00, c_start}) - $signed((CW + 2)'(r_eff));
	assign js0      = cx_ge_2r ? slot_sub(in_wslot_q, r2) : '0;

	logic signed [CW+1:0] fc_sv;
	logic                 j_adv;

	assign fc_sv = $signed({2'b00, fc_q}) - $signed((CW + 2)'(r_eff));
	assign j_adv = !jv_q[CW+1] && (jv_q < $signed({2'b00, wm1}));

	// Output availability: the last input it depends on must already be stored.
	logic [FH_W:0]          yr, ly;
	logic [CW:0]            xr, lx;
	logic                   avail, out_live, last_px;
	logic signed [FH_W+1:0] rv0;
	logic [SLOT_W-1:0]      rs0;
	logic signed [CW+1:0]   cv0;

	assign yr       = {1'b0, out_row_q} + (FH_W + 1)'(r_eff);
	assign ly       = (yr < {1'b0, hm1}) ? yr : {1'b0, hm1};
	assign xr       = {1'b0, out_col_q} + (CW + 1)'(r2);
	assign lx       = (xr < {1'b0, wm1}) ? xr : {1'b0, wm1};
	assign avail    = (ly < {1'b0, in_row_q}) ||
			((ly == {1'b0, in_row_q}) && (lx < {1'b0, in_col_q}));
	assign out_live = out_row_q <= hm1;
	assign last_px  = (out_row_q == hm1) && (out_col_q == wm1);
	assign rv0      = $signed({2'b00, out_row_q}) - $signed((FH_W + 2)'(r_eff));
	assign rs0      = (out_row_q >= FH_W'(r_eff)) ?
			slot_sub(out_rslot_q, SLOT_W'(r_eff)) : '0;
	assign cv0      = $signed({2'b00, out_col_q}) - $signed((CW + 2)'(r_eff));

	logic [CW-1:0] colc;
	logic          r_adv;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [PXW-1:0] wr_data;

	always_comb begin
		if (cv_q[CW+1]) begin
			colc = '0;
		end else if (cv_q > $signed({2'b00, wm1})) begin
			colc = wm1;
		end else begin
			colc = cv_q[CW-1:0];
		end
	end

	assign r_adv   = !rv_q[FH_W+1] && (rv_q < $signed({2'b00, hm1}));
	assign rd_addr = {rs_q, colc};
	assign wr_addr = {fslot_q, fc_q};

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			wr_data[PIX_W*ch +: PIX_W] = prod_q[ch][RECIP_SHIFT +: PIX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FP_WR) begin
			mem[wr_addr] <= wr_data;
		end
		if (state_q == O_RD) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	assign in_ready = (state_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rad_q       <= RAD_W'(1);
			fw_q        <= FW_W'(640);
			fh_q        <= FH_W'(480);
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_wslot_q  <= '0;
			in_rslot_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_rslot_q <= '0;
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
			rdv_s1      <= 1'b0;
			fc_q        <= '0;
			fe_q        <= '0;
			jv_q        <= '0;
			js_q        <= '0;
			jst_q       <= '0;
			fslot_q     <= '0;
			k_q         <= '0;
			cv_q        <= '0;
			rv_q        <= '0;
			rv0_q       <= '0;
			rs_q        <= '0;
			rs0_q       <= '0;
			kk_q        <= '0;
			m_q         <= '0;
			for (int i = 0; i < RING; i++) begin
				win_q[i] <= '0;
			end
			for (int ch = 0; ch < NCH; ch++) begin
				sum_q[ch]  <= '0;
				t_q[ch]    <= '0;
				acc_q[ch]  <= '0;
				prod_q[ch] <= '0;
				pix_q[ch]  <= '0;
			end
		end else begin
			rdv_s1 <= (state_q == O_RD);
			if (out_valid_q && out_ready && state_q != O_EMIT) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: rad_q <= cfg_data[RAD_W-1:0];
					REG_WIDTH:  fw_q  <= cfg_data[FW_W-1:0];
					REG_HEIGHT: fh_q  <= cfg_data[FH_W-1:0];
					default:    ;
				endcase
				if (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
						cfg_index == REG_HEIGHT) begin
					in_col_q    <= '0;
					in_row_q    <= '0;
					in_wslot_q  <= '0;
					in_rslot_q  <= '0;
					out_col_q   <= '0;
					out_row_q   <= '0;
					out_rslot_q <= '0;
				end
			end

			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						if (store && (cx_ge_r || cx_last)) begin
							state_q <= FP_ACC;
						end else begin
							state_q <= OUT_CHK;
						end
						if (store) begin
							win_q[in_wslot_q] <= {blue_in, green_in, red_in};
							if (cx_last) begin
								in_col_q   <= '0;
								in_wslot_q <= '0;
								in_row_q   <= in_row_q + 1'b1;
								in_rslot_q <= slot_inc(in_rslot_q);
							end else begin
								in_col_q   <= in_col_q + 1'b1;
								in_wslot_q <= slot_inc(in_wslot_q);
							end
							if (cx_ge_r || cx_last) begin
								fc_q    <= c_start;
								fe_q    <= c_end;
								jv_q    <= jv0;
								js_q    <= js0;
								jst_q   <= js0;
								k_q     <= '0;
								fslot_q <= in_rslot_q;
								for (int ch = 0; ch < NCH; ch++) begin
									sum_q[ch] <= '0;
								end
							end
						end
					end
				end
				FP_ACC: begin
					for (int ch = 0; ch < NCH; ch++) begin
						sum_q[ch] <= sum_q[ch] + SUM_W'(win_q[js_q][PIX_W*ch +: PIX_W]);
					end
					jv_q <= jv_q + 1'b1;
					if (j_adv) begin
						js_q <= slot_inc(js_q);
					end
					k_q <= k_q + 1'b1;
					if (k_q == r2) begin
						state_q <= FP_MUL;
					end
				end
				FP_MUL: begin
					for (int ch = 0; ch < NCH; ch++) begin
						prod_q[ch] <= PROD_W'(sum_q[ch]) * PROD_W'(recip);
					end
					state_q <= FP_WR;
				end
				FP_WR: begin
					if (fc_q == fe_q) begin
						state_q <= OUT_CHK;
					end else begin
						// The next window starts one column later, clamped at column zero.
						fc_q <= fc_q + 1'b1;
						jv_q <= fc_sv + 1'b1;
						if (fc_sv[CW+1]) begin
							js_q  <= '0;
							jst_q <= '0;
						end else begin
							js_q  <= slot_inc(jst_q);
							jst_q <= slot_inc(jst_q);
						end
						k_q <= '0;
						for (int ch = 0; ch < NCH; ch++) begin
							sum_q[ch] <= '0;
						end
						state_q <= FP_ACC;
					end
				end
				OUT_CHK: begin
					if (out_live && avail) begin
						cv_q  <= cv0;
						kk_q  <= '0;
						rv_q  <= rv0;
						rv0_q <= rv0;
						rs_q  <= rs0;
						rs0_q <= rs0;
						m_q   <= '0;
						for (int ch = 0; ch < NCH; ch++) begin
							t_q[ch]   <= '0;
							acc_q[ch] <= '0;
						end
						state_q <= O_RD;
					end else begin
						state_q <= IDLE;
					end
				end
				O_RD: begin
					if (rdv_s1) begin
						for (int ch = 0; ch < NCH; ch++) begin
							t_q[ch] <= t_q[ch] + SUM_W'(mem_rd_q[PIX_W*ch +: PIX_W]);
						end
					end
					rv_q <= rv_q + 1'b1;
					if (r_adv) begin
						rs_q <= slot_inc(rs_q);
					end
					m_q <= m_q + 1'b1;
					if (m_q == r2) begin
						state_q <= O_LAST;
					end
				end
				O_LAST: begin
					for (int ch = 0; ch < NCH; ch++) begin
						t_q[ch] <= t_q[ch] + SUM_W'(mem_rd_q[PIX_W*ch +: PIX_W]);
					end
					state_q <= O_MUL;
				end
				O_MUL: begin
					for (int ch = 0; ch < NCH; ch++) begin
						prod_q[ch] <= PROD_W'(t_q[ch]) * PROD_W'(recip);
					end
					state_q <= O_ADD;
				end
				O_ADD: begin
					for (int ch = 0; ch < NCH; ch++) begin
						acc_q[ch] <= acc_q[ch] + SUM_W'(prod_q[ch][RECIP_SHIFT +: PIX_W]);
						t_q[ch]   <= '0;
					end
					if (kk_q == r2) begin
						state_q <= O_FMUL;
					end else begin
						kk_q    <= kk_q + 1'b1;
						cv_q    <= cv_q + 1'b1;
						rv_q    <= rv0_q;
						rs_q    <= rs0_q;
						m_q     <= '0;
						state_q <= O_RD;
					end
				end
				O_FMUL: begin
					for (int ch = 0; ch < NCH; ch++) begin
						prod_q[ch] <= PROD_W'(acc_q[ch]) * PROD_W'(recip);
					end
					state_q <= O_EMIT;
				end
				O_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						frame_end_q <= last_px;
						for (int ch = 0; ch < NCH; ch++) begin
							pix_q[ch] <= prod_q[ch][RECIP_SHIFT +: PIX_W];
						end
						if (last_px) begin
							in_col_q    <= '0;
							in_row_q    <= '0;
							in_wslot_q  <= '0;
							in_rslot_q  <= '0;
							out_col_q   <= '0;
							out_row_q   <= '0;
							out_rslot_q <= '0;
						end else if (out_col_q == wm1) begin
							out_col_q   <= '0;
							out_row_q   <= out_row_q + 1'b1;
							out_rslot_q <= slot_inc(out_rslot_q);
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign frame_end = frame_end_q;
	assign red_out   = pix_q[0];
	assign green_out = pix_q[1];
	assign blue_out  = pix_q[2];

endmodule
